// ===== sv/ctc_pkg.sv =====
// Shared types and constants of the capture trigger controller.
package ctc_pkg;

   localparam int CMD_BYTES   = 16;
   localparam int MAGIC_BYTES = 4;

   localparam logic [3:0] LAST_BYTE   = 4'(CMD_BYTES - 1);
   localparam logic [3:0] MAGIC_LAST  = 4'(MAGIC_BYTES);

   localparam logic [7:0] MAX_FRAMES  = 8'd128;
   localparam logic [7:0] MAX_BLOCKS  = 8'd32;
   localparam logic [1:0] SKIP_BLOCKS = 2'd2;

   localparam logic [15:0] CODE_FLUSH      = 16'd1;
   localparam logic [15:0] CODE_CONTINUOUS = 16'd2;
   localparam logic [15:0] CODE_IDLE       = 16'd3;
   localparam logic [15:0] CODE_ARM_FRAMES = 16'd4;
   localparam logic [15:0] CODE_ARM_BLOCKS = 16'd5;
   localparam logic [15:0] CODE_STATUS     = 16'd6;

   localparam logic KIND_RESPONSE = 1'b0;
   localparam logic KIND_GRANT    = 1'b1;

   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_BLOCK = 1'b1;

   typedef enum logic [1:0] {
      MODE_CONT = 2'd0,
      MODE_IDLE = 2'd1,
      MODE_ARMF = 2'd2,
      MODE_ARMB = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_VERSION = 2'd1,
      ST_BAD_ARG     = 2'd2,
      ST_BAD_CMD     = 2'd3
   } status_type;

   typedef struct packed {
      logic        done;
      logic [15:0] version;
      logic [15:0] code;
      logic [31:0] seq;
      logic [31:0] arg;
   } cmd_type;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [15:0] cmd_code;
      logic [31:0] cmd_seq;
      status_type  status_code;
      mode_type    mode_now;
      logic [31:0] resp_value;
      logic [7:0]  emit_frames;
      logic        triggered;
   } rsp_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0: b = "P";
         2'd1: b = "G";
         2'd2: b = "M";
         2'd3: b = "C";
         default: b = "P";
      endcase
      return b;
   endfunction

endpackage

// ===== sv/ctc_cmd_asm.sv =====
// Command link parser: magic word search and little-endian command assembly.
module ctc_cmd_asm
   import ctc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output cmd_type    cmd
);

   logic [3:0] count_ff, count_in;
   logic [7:0] bytes_ff [4:14];
   logic       store;

   always_comb begin
      count_in = count_ff;
      store    = 1'b0;
      cmd.done = 1'b0;
      if (step) begin
         if (count_ff < MAGIC_LAST) begin
            if (rx_byte == magic_byte(count_ff[1:0])) begin
               count_in = count_ff + 4'd1;
            end else if (rx_byte == magic_byte(2'd0)) begin
               count_in = 4'd1;
            end else begin
               count_in = 4'd0;
            end
         end else if (count_ff == LAST_BYTE) begin
            count_in = 4'd0;
            cmd.done = 1'b1;
         end else begin
            store    = 1'b1;
            count_in = count_ff + 4'd1;
         end
      end
      cmd.version = {bytes_ff[5], bytes_ff[4]};
      cmd.code    = {bytes_ff[7], bytes_ff[6]};
      cmd.seq     = {bytes_ff[11], bytes_ff[10], bytes_ff[9], bytes_ff[8]};
      cmd.arg     = {rx_byte, bytes_ff[14], bytes_ff[13], bytes_ff[12]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         bytes_ff[count_ff] <= rx_byte;
      end
   end

endmodule

// ===== sv/ctc_trig_core.sv =====
// Trigger mode state, command execution and audio block grants.
module ctc_trig_core
   import ctc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   input  cmd_type     cmd,
   input  logic        blk_step,
   input  logic [7:0]  block_frames,
   output rsp_type     rsp
);

   mode_type    mode_ff, mode_in;
   logic [7:0]  armed_ff, armed_in;
   logic [1:0]  skip_ff, skip_in;
   logic [15:0] version_ff;
   logic [7:0]  lim;
   logic [7:0]  take;
   logic        blk_ok;

   assign blk_ok = blk_step && (block_frames != 8'd0) && (block_frames <= MAX_FRAMES);

   always_comb begin
      mode_in  = mode_ff;
      armed_in = armed_ff;
      skip_in  = skip_ff;
      lim      = MAX_FRAMES;
      take     = 8'd0;

      rsp.valid       = 1'b0;
      rsp.kind        = KIND_RESPONSE;
      rsp.cmd_code    = 16'd0;
      rsp.cmd_seq     = 32'd0;
      rsp.status_code = ST_OK;
      rsp.resp_value  = 32'd0;
      rsp.emit_frames = 8'd0;

      if (cmd.done) begin
         rsp.valid      = 1'b1;
         rsp.cmd_code   = cmd.code;
         rsp.cmd_seq    = cmd.seq;
         rsp.resp_value = cmd.arg;
         if (cmd.version != version_ff) begin
            rsp.status_code = ST_BAD_VERSION;
            rsp.resp_value  = {16'd0, cmd.version};
         end else begin
            case (cmd.code)
               CODE_FLUSH: begin
                  rsp.resp_value = 32'd0;
               end
               CODE_CONTINUOUS, CODE_IDLE: begin
                  mode_in  = (cmd.code == CODE_CONTINUOUS) ? MODE_CONT : MODE_IDLE;
                  armed_in = 8'd0;
                  skip_in  = 2'd0;
               end
               CODE_ARM_FRAMES, CODE_ARM_BLOCKS: begin
                  lim = (cmd.code == CODE_ARM_FRAMES) ? MAX_FRAMES : MAX_BLOCKS;
                  if (cmd.arg == 32'd0 || cmd.arg > {24'd0, lim}) begin
                     rsp.status_code = ST_BAD_ARG;
                     rsp.resp_value  = {24'd0, lim};
                  end else begin
                     mode_in  = (cmd.code == CODE_ARM_FRAMES) ? MODE_ARMF : MODE_ARMB;
                     armed_in = cmd.arg[7:0];
                     skip_in  = SKIP_BLOCKS;
                  end
               end
               CODE_STATUS: begin
                  rsp.resp_value = {24'd0, armed_ff};
               end
               default: begin
                  rsp.status_code = ST_BAD_CMD;
               end
            endcase
         end
      end else if (blk_ok) begin
         rsp.valid = 1'b1;
         rsp.kind  = KIND_GRANT;
         case (mode_ff)
            MODE_IDLE: take = 8'd0;
            MODE_CONT: take = block_frames;
            default: begin
               if (skip_ff != 2'd0) begin
                  skip_in = skip_ff - 2'd1;
               end else if (armed_ff == 8'd0) begin
                  mode_in = MODE_IDLE;
               end else begin
                  if (mode_ff == MODE_ARMB) begin
                     take     = block_frames;
                     armed_in = armed_ff - 8'd1;
                  end else begin
                     take     = (block_frames < armed_ff) ? block_frames : armed_ff;
                     armed_in = armed_ff - take;
                  end
                  if (armed_in == 8'd0) begin
                     mode_in = MODE_IDLE;
                  end
               end
            end
         endcase
         rsp.emit_frames = take;
      end

      rsp.mode_now  = mode_in;
      rsp.triggered = (mode_in != MODE_CONT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_CONT;
         armed_ff   <= 8'd0;
         skip_ff    <= 2'd0;
         version_ff <= 16'd1;
      end else begin
         mode_ff  <= mode_in;
         armed_ff <= armed_in;
         skip_ff  <= skip_in;
         if (csr_we) begin
            version_ff <= csr_wdata;
         end
      end
   end

endmodule

// ===== sv/capture_trigger_controller.sv =====
// Top level of the capture trigger controller: input stage, command parser, core and result register.
//
//  Channel  Direction  Payload
//  req_     in         tuser func; tdata rx_byte, block_frames
//  rsp_     out        tuser kind; tdata response or grant fields
//  csr_     in         expected_version, write only
//
// Each accepted item waits in the input register until the result register is free or being drained.
// One item is accepted per cycle while the result does not stall; the input register and the result register set that.
// Reset clears the stage valid bits, the mode state and sets the expected version to 1.
// A stalled result holds the input stage, and req_tready falls only when both are full.
module capture_trigger_controller
   import ctc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // rx_byte, block_frames
   input  logic        req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // cmd_code, cmd_seq, status_code, mode_now,
                                   // resp_value, emit_frames, triggered, zero fill
   output logic        rsp_tuser,  // kind
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic        in_valid_ff;
   logic [15:0] in_data_ff;
   logic        in_func_ff;
   logic        out_valid_ff;
   logic [95:0] out_data_ff;
   logic        out_kind_ff;
   logic        advance;
   cmd_type     cmd;
   rsp_type     rsp;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ctc_cmd_asm u_cmd_asm (
      .clock   (clock),
      .reset   (reset),
      .step    (advance && (in_func_ff == FUNC_BYTE)),
      .rx_byte (in_data_ff[7:0]),
      .cmd     (cmd)
   );

   ctc_trig_core u_trig_core (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .blk_step     (advance && (in_func_ff == FUNC_BLOCK)),
      .block_frames (in_data_ff[15:8]),
      .rsp          (rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= rsp.valid;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_data_ff <= req_tdata;
         in_func_ff <= req_tuser;
      end
      if (advance && rsp.valid) begin
         out_kind_ff <= rsp.kind;
         out_data_ff <= {3'd0, rsp.triggered, rsp.emit_frames, rsp.resp_value,
                         rsp.mode_now, rsp.status_code, rsp.cmd_seq, rsp.cmd_code};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;

   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stage stalled without a stalled result");

   a_trig_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[92] == (rsp_tdata[51:50] != MODE_CONT)))
      else $error("triggered flag disagrees with mode");

   a_resp_no_frames: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_RESPONSE) |-> (rsp_tdata[91:84] == 8'd0))
      else $error("command response carries frames");

   a_grant_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_GRANT) |->
         (rsp_tdata[91:84] <= MAX_FRAMES && rsp_tdata[83:0] == {32'd0, rsp_tdata[51:50], 50'd0}))
      else $error("grant fields out of range");

endmodule

// ===== tb/ctc_checker.sv =====
// Checker for the capture trigger controller: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module ctc_checker
   import ctc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          answers_outstanding
);

   localparam logic [31:0] MAGIC_WORD = {"C", "M", "G", "P"};

   typedef struct {
      logic        kind;
      logic [15:0] code;
      logic [31:0] seq;
      status_type  status;
      mode_type    mode;
      logic [31:0] value;
      logic [7:0]  emit;
      logic        trig;
   } answer_type;

   answer_type  answers_due[$];
   logic [15:0] version_reg;
   logic [4:0]  match_count;
   logic [7:0]  cmd_bytes [16];
   mode_type    mode_q;
   logic [7:0]  armed_left;
   logic [1:0]  skip_left;

   function automatic void execute_command();
      logic [15:0] ver;
      logic [15:0] code;
      logic [31:0] seq;
      logic [31:0] arg;
      logic [31:0] value;
      logic [31:0] lim;
      status_type  st;
      answer_type  a;
      ver   = {cmd_bytes[5], cmd_bytes[4]};
      code  = {cmd_bytes[7], cmd_bytes[6]};
      seq   = {cmd_bytes[11], cmd_bytes[10], cmd_bytes[9], cmd_bytes[8]};
      arg   = {cmd_bytes[15], cmd_bytes[14], cmd_bytes[13], cmd_bytes[12]};
      st    = ST_OK;
      value = arg;
      if (ver != version_reg) begin
         st    = ST_BAD_VERSION;
         value = {16'd0, ver};
      end else if (code == CODE_FLUSH) begin
         value = '0;
      end else if (code == CODE_CONTINUOUS || code == CODE_IDLE) begin
         mode_q     = (code == CODE_CONTINUOUS) ? MODE_CONT : MODE_IDLE;
         armed_left = '0;
         skip_left  = '0;
      end else if (code == CODE_ARM_FRAMES || code == CODE_ARM_BLOCKS) begin
         lim = (code == CODE_ARM_FRAMES) ? 32'(MAX_FRAMES) : 32'(MAX_BLOCKS);
         if (arg == 0 || arg > lim) begin
            st    = ST_BAD_ARG;
            value = lim;
         end else begin
            mode_q     = (code == CODE_ARM_FRAMES) ? MODE_ARMF : MODE_ARMB;
            armed_left = arg[7:0];
            skip_left  = SKIP_BLOCKS;
         end
      end else if (code == CODE_STATUS) begin
         value = {24'd0, armed_left};
      end else begin
         st = ST_BAD_CMD;
      end
      a.kind   = KIND_RESPONSE;
      a.code   = code;
      a.seq    = seq;
      a.status = st;
      a.mode   = mode_q;
      a.value  = value;
      a.emit   = '0;
      a.trig   = (mode_q != MODE_CONT);
      answers_due.push_back(a);
   endfunction

   function automatic logic [7:0] grant_block(input logic [7:0] frames);
      logic [7:0] take;
      if (mode_q == MODE_IDLE) return 8'd0;
      if (mode_q == MODE_CONT) return frames;
      if (skip_left != 0) begin
         skip_left--;
         return 8'd0;
      end
      if (armed_left == 0) begin
         mode_q = MODE_IDLE;
         return 8'd0;
      end
      if (mode_q == MODE_ARMB) begin
         armed_left--;
         take = frames;
      end else begin
         take       = (frames < armed_left) ? frames : armed_left;
         armed_left = armed_left - take;
      end
      if (armed_left == 0) mode_q = MODE_IDLE;
      return take;
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      if (match_count < 4) begin
         if (b == MAGIC_WORD[8*int'(match_count) +: 8]) begin
            cmd_bytes[match_count[3:0]] = b;
            match_count++;
         end else if (b == MAGIC_WORD[7:0]) begin
            cmd_bytes[0] = b;
            match_count  = 5'd1;
         end else begin
            match_count = 5'd0;
         end
      end else begin
         cmd_bytes[match_count[3:0]] = b;
         match_count++;
         if (match_count >= 16) begin
            match_count = 5'd0;
            execute_command();
         end
      end
   endfunction

   function automatic void take_block(input logic [7:0] frames);
      answer_type a;
      if (frames == 0 || frames > MAX_FRAMES) return;
      a.emit   = grant_block(frames);
      a.kind   = KIND_GRANT;
      a.code   = '0;
      a.seq    = '0;
      a.status = ST_OK;
      a.mode   = mode_q;
      a.value  = '0;
      a.trig   = (mode_q != MODE_CONT);
      answers_due.push_back(a);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endfunction

   function automatic void compare_answer();
      answer_type a;
      if (answers_due.size() == 0) begin
         $error("result item with no expectation waiting: kind %0h data %0h",
                rsp_tuser, rsp_tdata);
         mismatch_count++;
         return;
      end
      a = answers_due.pop_front();
      check_field("kind",        a.kind,   rsp_tuser);
      check_field("cmd_code",    a.code,   rsp_tdata[15:0]);
      check_field("cmd_seq",     a.seq,    rsp_tdata[47:16]);
      check_field("status_code", a.status, rsp_tdata[49:48]);
      check_field("mode_now",    a.mode,   rsp_tdata[51:50]);
      check_field("resp_value",  a.value,  rsp_tdata[83:52]);
      check_field("emit_frames", a.emit,   rsp_tdata[91:84]);
      check_field("triggered",   a.trig,   rsp_tdata[92]);
      check_field("zero fill",   '0,       rsp_tdata[95:93]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         version_reg = 16'd1;
         match_count = '0;
         mode_q      = MODE_CONT;
         armed_left  = '0;
         skip_left   = '0;
         answers_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_answer();
         if (req_tvalid && req_tready) begin
            if (req_tuser == FUNC_BYTE) take_byte(req_tdata[7:0]);
            else take_block(req_tdata[15:8]);
         end
         if (csr_we) version_reg = csr_wdata;
      end
      answers_outstanding = answers_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the capture trigger controller: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top
   import ctc_pkg::*;
();

   localparam int          HOLD_CYCLES   = 300;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          PHASE_ITEMS   = 185;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          DRAIN_CYCLES  = 20;
   localparam logic [31:0] MAGIC_WORD    = {"C", "M", "G", "P"};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [15:0] csr_wdata;

   int          mismatch_count;
   int          answers_outstanding;
   int          cycles = 0;
   int          items_sent = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        hold_req = 1'b0;
   logic        hold_done;
   logic [15:0] version_now;

   capture_trigger_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   ctc_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .req_tuser           (req_tuser),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .rsp_tuser           (rsp_tuser),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .answers_outstanding (answers_outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done <= 1'b1;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(input logic func, input logic [7:0] value);
      logic [15:0] payload;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 16'($urandom);
         req_tuser  <= 1'($urandom);
         @(negedge clock);
      end
      payload = 16'($urandom);
      if (func == FUNC_BYTE) payload[7:0] = value;
      else payload[15:8] = value;
      req_tvalid <= 1'b1;
      req_tdata  <= payload;
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (!(func == FUNC_BLOCK && (value == 0 || value > MAX_FRAMES))) items_sent++;
   endtask

   task automatic send_command(input logic [15:0] ver, input logic [15:0] code,
                               input logic [31:0] seq, input logic [31:0] arg);
      logic [95:0] body;
      body = {arg, seq, code, ver};
      for (int i = 0; i < 4; i++) send_item(FUNC_BYTE, MAGIC_WORD[8*i +: 8]);
      for (int i = 0; i < 12; i++) begin
         if ($urandom_range(99) < 3) send_item(FUNC_BLOCK, 8'($urandom_range(128, 1)));
         send_item(FUNC_BYTE, body[8*i +: 8]);
      end
   endtask

   task automatic set_version(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (answers_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      version_now = value;
   endtask

   task automatic random_unit();
      int          pick;
      int          k;
      logic [15:0] code;
      logic [31:0] arg;
      logic [31:0] lim;
      pick = $urandom_range(99);
      if (pick < 50) begin
         if ($urandom_range(99) < 85) begin
            code = 16'($urandom_range(6, 1));
         end else begin
            case ($urandom_range(2))
               0: code = 16'd0;
               1: code = 16'd7;
               default: code = 16'($urandom);
            endcase
         end
         if (code == CODE_ARM_FRAMES || code == CODE_ARM_BLOCKS) begin
            lim = (code == CODE_ARM_FRAMES) ? 32'(MAX_FRAMES) : 32'(MAX_BLOCKS);
            case ($urandom_range(5))
               0: arg = 32'd0;
               1: arg = lim;
               2: arg = lim + 1;
               3: arg = $urandom;
               default: arg = $urandom_range(lim, 1);
            endcase
         end else begin
            arg = $urandom;
         end
         send_command(($urandom_range(99) < 85) ? version_now : 16'($urandom),
                      code, $urandom, arg);
      end else if (pick < 85) begin
         case ($urandom_range(9))
            0: send_item(FUNC_BLOCK, 8'd0);
            1: send_item(FUNC_BLOCK, 8'($urandom_range(255, 129)));
            2: send_item(FUNC_BLOCK, MAX_FRAMES);
            default: send_item(FUNC_BLOCK, 8'($urandom_range(128, 1)));
         endcase
      end else if (pick < 93) begin
         repeat ($urandom_range(4, 1)) send_item(FUNC_BYTE, 8'($urandom));
      end else begin
         k = $urandom_range(3, 1);
         for (int i = 0; i < k; i++) send_item(FUNC_BYTE, MAGIC_WORD[8*i +: 8]);
         send_item(FUNC_BYTE, 8'($urandom));
      end
   endtask

   task automatic run_phase(input int sender_idle, input int receiver_idle);
      send_idle_pct = sender_idle;
      recv_idle_pct = receiver_idle;
      items_sent    = 0;
      while (items_sent < PHASE_ITEMS) random_unit();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_BYTE;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      version_now = 16'd1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(FUNC_BLOCK, 8'd0);
      send_item(FUNC_BLOCK, 8'd129);
      send_item(FUNC_BLOCK, 8'd255);
      send_item(FUNC_BLOCK, 8'd1);
      send_item(FUNC_BLOCK, MAX_FRAMES);
      send_command(16'd1, CODE_STATUS, 32'h0000_0000, 32'hFFFF_FFFF);
      // A broken magic followed by a fresh one exercises the restart on the first magic byte.
      send_item(FUNC_BYTE, MAGIC_WORD[7:0]);
      send_item(FUNC_BYTE, MAGIC_WORD[15:8]);
      send_command(16'd0, CODE_IDLE, 32'hFFFF_FFFF, 32'd0);
      send_command(16'd1, CODE_ARM_FRAMES, 32'd1, 32'd0);
      send_command(16'd1, CODE_ARM_FRAMES, 32'd2, 32'd129);
      send_command(16'd1, CODE_ARM_FRAMES, 32'd3, 32'd3);
      send_item(FUNC_BLOCK, 8'd5);
      send_item(FUNC_BLOCK, 8'd5);
      send_item(FUNC_BLOCK, 8'd2);
      send_item(FUNC_BLOCK, 8'd5);
      send_item(FUNC_BLOCK, 8'd7);
      send_command(16'd1, CODE_ARM_BLOCKS, 32'd4, 32'd33);
      send_command(16'd1, CODE_ARM_BLOCKS, 32'd5, 32'd1);
      send_command(16'd1, CODE_STATUS, 32'd6, 32'd0);
      repeat (4) send_item(FUNC_BLOCK, 8'd100);
      send_command(16'd1, 16'd0, 32'd7, 32'h1234_5678);
      send_command(16'd1, 16'hFFFF, 32'd8, 32'd9);
      send_command(16'd1, CODE_FLUSH, 32'd9, 32'hFFFF_FFFF);
      send_command(16'd1, CODE_CONTINUOUS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      set_version(16'h0000);
      run_phase(23, 79);
      set_version(16'hFFFF);
      run_phase(79, 23);
      set_version(16'($urandom));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req = 1'b1;
      repeat (30) send_item(FUNC_BLOCK, 8'($urandom_range(128, 1)));
      run_phase(0, 0);

      req_tvalid <= 1'b0;
      while (answers_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== capture_trigger_controller.f =====
sv/ctc_pkg.sv
sv/ctc_cmd_asm.sv
sv/ctc_trig_core.sv
sv/capture_trigger_controller.sv
tb/ctc_checker.sv
tb/tb_top.sv
